@@ sv/pointcloud_to_polar_min_scan_top_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the polar minimum scan block
// Shared shorthand for clocked assertions, all disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef POINTCLOUD_TO_POLAR_MIN_SCAN_TOP_DEFINES_SVH
`define POINTCLOUD_TO_POLAR_MIN_SCAN_TOP_DEFINES_SVH

// The property must hold at every clock edge outside reset.
`define PTPMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// The boolean condition must never be seen outside reset.
`define PTPMS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

@@ sv/ptpms_pkg.sv @@
// ----------------------------------------------------------------------------
// Polar minimum scan package
// Shared widths, register indexes and the arctangent table builder.
// ----------------------------------------------------------------------------
package ptpms_pkg;

  // Widths fixed by the register and result fields.
  localparam int STORE_W    = 24;
  localparam int RANGE_W    = 23;
  localparam int ANGLE_W    = 20;
  localparam int DIVIDEND_W = 20;
  localparam int STEP_W     = 19;
  localparam int START_W    = 19;
  localparam int COUNT_W    = 11;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int BIN_NUM_W  = 10;

  localparam int CORDIC_ITERS = 40;
  localparam logic [STORE_W-1:0] EMPTY_MARK = 24'hFF_FFFF;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEIGHT_UPPER = 3'd0,
    REG_HEIGHT_LOWER = 3'd1,
    REG_DIST_UPPER   = 3'd2,
    REG_DIST_LOWER   = 3'd3,
    REG_ANGLE_START  = 3'd4,
    REG_ANGLE_STEP   = 3'd5,
    REG_BIN_COUNT    = 3'd6
  } cfg_reg_e;

  // Restoring division, used only to build constants at elaboration.
  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int k = 63; k >= 0; k--) begin
      r = {r[63:0], a[k]};
      if (r >= {1'b0, b}) begin
        r = r - {1'b0, b};
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  // Truncated arctangent series of 1/n in units of 2^-56 radian.
  function automatic logic [63:0] atan_recip(input logic [63:0] n);
    logic [63:0] p;
    logic [63:0] nn;
    logic [63:0] sum;
    logic [63:0] t;
    p   = udiv64(64'h4000_0000_0000_0000, n);
    nn  = n * n;
    sum = '0;
    for (int k = 0; k < 64; k++) begin
      if (p != '0) begin
        t = udiv64(p, 64'(2 * k + 1));
        if (k[0]) sum = sum - t;
        else      sum = sum + t;
        p = udiv64(p, nn);
      end
    end
    return sum >> 6;
  endfunction

  // One entry of the CORDIC angle table.
  function automatic logic [63:0] atan_entry(input int i);
    logic [63:0] v;
    if (i == 0) begin
      v = atan_recip(64'd2) + atan_recip(64'd3);
    end else if (i < 20) begin
      v = atan_recip(64'd1 << i);
    end else begin
      v = 64'd1 << (56 - i);
    end
    return v;
  endfunction

endpackage

@@ sv/ptpms_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One address per cycle with an optional write, read data registered.
// ----------------------------------------------------------------------------
module ptpms_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read of the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/ptpms_cordic.sv @@
// ----------------------------------------------------------------------------
// Iterative CORDIC vectoring unit
// Turns (x, y) into atan2(y, x) in radians times 2^16, one rotation per cycle.
// ----------------------------------------------------------------------------
module ptpms_cordic #(
  parameter int COORD_BITS = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [COORD_BITS-1:0]         x_i,
  input  logic signed [COORD_BITS-1:0]         y_i,
  output logic                                 busy_o,
  output logic                                 done_o,
  output logic signed [ptpms_pkg::ANGLE_W-1:0] angle_o
);
  import ptpms_pkg::*;

  localparam int ScaleShift = 61 - COORD_BITS;
  localparam int VW = 66;
  localparam int ZW = 64;
  localparam int IW = $clog2(CORDIC_ITERS);
  localparam logic signed [ZW-1:0] RoundHalf = ZW'(64'd1 << 39);

  logic signed [ZW-1:0] atan_tab [CORDIC_ITERS];
  logic signed [ZW-1:0] half_pi;
  logic signed [VW-1:0] xs, ys, x_init, y_init;
  logic signed [ZW-1:0] z_init;
  logic signed [VW-1:0] dx, dy, x_nx, y_nx;
  logic signed [ZW-1:0] z_nx, z_rnd;
  logic signed [VW-1:0] x_q, y_q;
  logic signed [ZW-1:0] z_q;
  logic [IW-1:0]        iter_q;
  logic                 busy_q, done_q, zero_q;
  logic signed [ANGLE_W-1:0] angle_q;

  // Constant angle table, one entry per rotation.
  for (genvar g = 0; g < CORDIC_ITERS; g++) begin : g_atan
    localparam logic [63:0] AtanVal = atan_entry(g);
    assign atan_tab[g] = $signed(AtanVal);
  end

  assign half_pi = atan_tab[0] <<< 1;

  // Scale the inputs and fold the left half plane into the right.
  always_comb begin
    xs = VW'(x_i) <<< ScaleShift;
    ys = VW'(y_i) <<< ScaleShift;
    if (xs[VW-1]) begin
      if (!ys[VW-1]) begin
        x_init = ys;
        y_init = -xs;
        z_init = half_pi;
      end else begin
        x_init = -ys;
        y_init = xs;
        z_init = -half_pi;
      end
    end else begin
      x_init = xs;
      y_init = ys;
      z_init = '0;
    end
  end

  // One micro-rotation toward the x axis.
  always_comb begin
    dx = y_q >>> iter_q;
    dy = x_q >>> iter_q;
    if (!y_q[VW-1]) begin
      x_nx = x_q + dx;
      y_nx = y_q - dy;
      z_nx = z_q + atan_tab[iter_q];
    end else begin
      x_nx = x_q - dx;
      y_nx = y_q + dy;
      z_nx = z_q - atan_tab[iter_q];
    end
    z_rnd = z_nx + RoundHalf;
  end

  // Sequencing of the rotations.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        iter_q <= '0;
      end else if (busy_q) begin
        iter_q <= iter_q + 1'b1;
        if (iter_q == IW'(CORDIC_ITERS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= x_init;
      y_q    <= y_init;
      z_q    <= z_init;
      zero_q <= (x_i == '0) && (y_i == '0);
    end else if (busy_q) begin
      x_q <= x_nx;
      y_q <= y_nx;
      z_q <= z_nx;
      if (iter_q == IW'(CORDIC_ITERS - 1)) begin
        angle_q <= zero_q ? '0 : z_rnd[40 +: ANGLE_W];
      end
    end
  end

  assign busy_o  = busy_q;
  assign done_o  = done_q;
  assign angle_o = angle_q;

endmodule

@@ sv/ptpms_div.sv @@
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division of the angle offset by the bin width, one bit per cycle.
// ----------------------------------------------------------------------------
module ptpms_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [ptpms_pkg::DIVIDEND_W-1:0]    dividend_i,
  input  logic [ptpms_pkg::STEP_W-1:0]        divisor_i,
  output logic                                done_o,
  output logic [ptpms_pkg::DIVIDEND_W-1:0]    quotient_o
);
  import ptpms_pkg::*;

  localparam int CW = $clog2(DIVIDEND_W);

  logic [DIVIDEND_W-1:0] quo_q;
  logic [STEP_W-1:0]     rem_q, rem_nx;
  logic [STEP_W:0]       sh;
  logic                  fits;
  logic [CW-1:0]         cnt_q;
  logic                  busy_q, done_q;

  // Shift in the next dividend bit and try a subtraction.
  always_comb begin
    sh     = {rem_q, quo_q[DIVIDEND_W-1]};
    fits   = sh >= {1'b0, divisor_i};
    rem_nx = fits ? STEP_W'(sh - {1'b0, divisor_i}) : STEP_W'(sh);
  end

  // Bit counter and handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(DIVIDEND_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
      rem_q <= rem_nx;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ sv/ptpms_isqrt.sv @@
// ----------------------------------------------------------------------------
// Serial integer square root
// Floor square root, one result bit per cycle from the top.
// ----------------------------------------------------------------------------
module ptpms_isqrt #(
  parameter int IN_W = 49,
  parameter int N    = (IN_W + 1) / 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [IN_W-1:0] value_i,
  output logic            busy_o,
  output logic [N-1:0]    root_o
);

  localparam int CW = $clog2(N + 1);

  logic [2*N-1:0] val_q;
  logic [N:0]     rem_q;
  logic [N-1:0]   root_q;
  logic [N+2:0]   sh, trial;
  logic           fits;
  logic [CW-1:0]  cnt_q;
  logic           busy_q;

  // Bring down the next bit pair and test the trial subtrahend.
  always_comb begin
    sh    = {rem_q, val_q[2*N-1 -: 2]};
    trial = {1'b0, root_q, 2'b01};
    fits  = sh >= trial;
  end

  // Step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(N - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Remainder, root and operand shift registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q  <= (2*N)'(value_i);
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      val_q  <= val_q << 2;
      rem_q  <= fits ? (N+1)'(sh - trial) : (N+1)'(sh);
      root_q <= {root_q[N-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

@@ sv/pointcloud_to_polar_min_scan_top.sv @@
// ----------------------------------------------------------------------------
// Polar minimum scan, top level
// Bins filtered points by planar angle, keeps the nearest range per bin and
// reads the bins out in order, clearing each one as it is read.
// ----------------------------------------------------------------------------
// A point request holds the block from the cycle in which it is accepted until
// it is through: the shared squaring multiplier, the filter check, the CORDIC
// angle unit (the square root runs alongside it), the serial divider and the
// read-modify-write of the bin memory. A point that fails a filter leaves after
// the filter check, one whose angle lies below the scan after the angle unit and
// one past the last bin after the bin check. A read-out request holds the block
// for a memory read and the output step plus any wait for the output register.
// The block is ready again in the following cycle, so a new point is taken only
// after the last one is through. After reset the bin memory is swept to empty,
// one entry per cycle, during which no request is taken; configuration writes
// are taken at any time.
`include "pointcloud_to_polar_min_scan_top_defines.svh"

module pointcloud_to_polar_min_scan_top #(
  parameter int MAX_BINS   = 1024,
  parameter int COORD_BITS = 24
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic                                    kind_i,
  input  logic signed [COORD_BITS-1:0]            px_i,
  input  logic signed [COORD_BITS-1:0]            py_i,
  input  logic signed [COORD_BITS-1:0]            pz_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic [ptpms_pkg::BIN_NUM_W-1:0]         bin_number_o,
  output logic [ptpms_pkg::RANGE_W-1:0]           range_mm_o,
  output logic                                    last_bin_o,
  output logic                                    config_bad_o,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [ptpms_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [ptpms_pkg::CFG_DATA_W-1:0]        cfg_data_i
);
  import ptpms_pkg::*;

  localparam int AW   = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int MW   = (COORD_BITS > RANGE_W) ? COORD_BITS : RANGE_W;
  localparam int SQW  = 2 * MW;
  localparam int PLW  = SQW + 1;
  localparam int D2W  = SQW + 2;
  localparam int HW   = (COORD_BITS > STORE_W) ? COORD_BITS : STORE_W;
  localparam int RN   = (PLW + 1) / 2;
  localparam int DFW  = DIVIDEND_W + 1;

  typedef enum logic [10:0] {
    S_CLEAR  = 11'b000_0000_0001,
    S_IDLE   = 11'b000_0000_0010,
    S_SQ     = 11'b000_0000_0100,
    S_CHECK  = 11'b000_0000_1000,
    S_CORDIC = 11'b000_0001_0000,
    S_DIV    = 11'b000_0010_0000,
    S_BIN    = 11'b000_0100_0000,
    S_RD     = 11'b000_1000_0000,
    S_UPD    = 11'b001_0000_0000,
    S_RO_RD  = 11'b010_0000_0000,
    S_RO_OUT = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic signed [STORE_W-1:0] hu_q, hl_q;
  logic [RANGE_W-1:0]        dup_q, dlo_q;
  logic signed [START_W-1:0] as_q;
  logic [STEP_W-1:0]         step_q;
  logic [COUNT_W-1:0]        bc_q;

  // Point datapath.
  logic signed [COORD_BITS-1:0] px_q, py_q, pz_q;
  logic [COORD_BITS-1:0] mag_x, mag_y, mag_z;
  logic [MW-1:0]   op;
  logic [SQW-1:0]  prod, mul_q, dup2_q, dlo2_q;
  logic [PLW-1:0]  plane_q;
  logic [D2W-1:0]  d2_q;
  logic [2:0]      mstep_q;
  logic signed [HW-1:0] z_ext, hu_ext, hl_ext;
  logic            bad, keep;

  logic            cordic_start, cordic_busy, cordic_done;
  logic signed [ANGLE_W-1:0] angle;
  logic signed [DFW-1:0]     diff;
  logic            div_start, div_done;
  logic [DIVIDEND_W-1:0]     quotient;
  logic            sqrt_busy;
  logic [RN-1:0]   root;
  logic [STORE_W-1:0] range_sat;

  // Bin memory and read-out.
  logic [AW-1:0]      clr_q, bin_q, ptr_q, p_eff, ram_addr;
  logic               ram_we;
  logic [STORE_W-1:0] ram_wdata, ram_rdata, ro_val;
  logic [COUNT_W-1:0] bins_used;
  logic               ro_last, slot_free;

  // Output register.
  logic                 out_valid_q, last_q, bad_q;
  logic [BIN_NUM_W-1:0] bin_number_q;
  logic [RANGE_W-1:0]   range_q;

  assign cfg_ready_o = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hu_q   <= 24'sd8388607;
      hl_q   <= -24'sd8388608;
      dup_q  <= 23'd8388607;
      dlo_q  <= '0;
      as_q   <= -19'sd205888;
      step_q <= 19'd402;
      bc_q   <= 11'd1024;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_HEIGHT_UPPER: hu_q   <= $signed(cfg_data_i[STORE_W-1:0]);
        REG_HEIGHT_LOWER: hl_q   <= $signed(cfg_data_i[STORE_W-1:0]);
        REG_DIST_UPPER:   dup_q  <= cfg_data_i[RANGE_W-1:0];
        REG_DIST_LOWER:   dlo_q  <= cfg_data_i[RANGE_W-1:0];
        REG_ANGLE_START:  as_q   <= $signed(cfg_data_i[START_W-1:0]);
        REG_ANGLE_STEP:   step_q <= cfg_data_i[STEP_W-1:0];
        REG_BIN_COUNT:    bc_q   <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Bins in use and the effective read-out pointer.
  always_comb begin
    if (bc_q == '0) begin
      bins_used = COUNT_W'(1);
    end else if (int'(bc_q) > MAX_BINS) begin
      bins_used = COUNT_W'(MAX_BINS);
    end else begin
      bins_used = bc_q;
    end
    p_eff   = (32'(ptr_q) >= 32'(bins_used)) ? '0 : ptr_q;
    ro_last = 32'(p_eff) == (32'(bins_used) - 32'd1);
    bad     = (hu_q < hl_q) || (dup_q < dlo_q);
  end

  // Operand magnitudes and the shared squaring multiplier.
  always_comb begin
    mag_x = px_q[COORD_BITS-1] ? COORD_BITS'(-px_q) : COORD_BITS'(px_q);
    mag_y = py_q[COORD_BITS-1] ? COORD_BITS'(-py_q) : COORD_BITS'(py_q);
    mag_z = pz_q[COORD_BITS-1] ? COORD_BITS'(-pz_q) : COORD_BITS'(pz_q);
    case (mstep_q)
      3'd0:    op = MW'(mag_x);
      3'd1:    op = MW'(mag_y);
      3'd2:    op = MW'(mag_z);
      3'd3:    op = MW'(dup_q);
      3'd4:    op = MW'(dlo_q);
      default: op = '0;
    endcase
    prod = op * op;
  end

  // Height and distance windows, angle offset and saturated range.
  always_comb begin
    z_ext  = HW'(pz_q);
    hu_ext = HW'(hu_q);
    hl_ext = HW'(hl_q);
    keep   = !bad && (step_q != '0) && (z_ext <= hu_ext) && (z_ext > hl_ext) &&
             (d2_q <= D2W'(dup2_q)) && (d2_q >= D2W'(dlo2_q));
    diff   = DFW'(angle) - DFW'(as_q);
    range_sat = (root > RN'(EMPTY_MARK)) ? EMPTY_MARK : STORE_W'(root);
  end

  assign slot_free    = !out_valid_q || out_ready_i;
  assign cordic_start = (state_q == S_CHECK) && keep;
  assign div_start    = (state_q == S_CORDIC) && cordic_done && !diff[DFW-1];

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:  if (clr_q == AW'(MAX_BINS - 1)) state_d = S_IDLE;
      S_IDLE:   if (in_valid_i) state_d = kind_i ? S_RO_RD : S_SQ;
      S_SQ:     if (mstep_q == 3'd5) state_d = S_CHECK;
      S_CHECK:  state_d = keep ? S_CORDIC : S_IDLE;
      S_CORDIC: if (cordic_done) state_d = diff[DFW-1] ? S_IDLE : S_DIV;
      S_DIV:    if (div_done) state_d = S_BIN;
      S_BIN:    state_d = (32'(quotient) < 32'(bins_used)) ? S_RD : S_IDLE;
      S_RD:     state_d = S_UPD;
      S_UPD:    state_d = S_IDLE;
      S_RO_RD:  state_d = S_RO_OUT;
      S_RO_OUT: if (slot_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Memory port selection.
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = EMPTY_MARK;
    case (state_q)
      S_CLEAR: begin
        ram_addr = clr_q;
        ram_we   = 1'b1;
      end
      S_UPD: begin
        ram_addr  = bin_q;
        ram_wdata = range_sat;
        ram_we    = range_sat < ram_rdata;
      end
      S_RO_RD:  ram_addr = p_eff;
      S_RO_OUT: begin
        ram_addr = p_eff;
        ram_we   = slot_free;
      end
      default:  ram_addr = bin_q;
    endcase
    ro_val = (ram_rdata > STORE_W'(dup_q)) ? STORE_W'(dup_q) : ram_rdata;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      mstep_q     <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
      if (state_q == S_SQ) mstep_q <= mstep_q + 1'b1;
      else                 mstep_q <= '0;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if ((state_q == S_RO_OUT) && slot_free) begin
        out_valid_q <= 1'b1;
        ptr_q       <= ro_last ? '0 : p_eff + 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && in_valid_i) begin
      px_q <= px_i;
      py_q <= py_i;
      pz_q <= pz_i;
    end
    mul_q <= prod;
    if (state_q == S_SQ) begin
      case (mstep_q)
        3'd1:    plane_q <= PLW'(mul_q);
        3'd2:    plane_q <= plane_q + PLW'(mul_q);
        3'd3:    d2_q    <= D2W'(plane_q) + D2W'(mul_q);
        3'd4:    dup2_q  <= mul_q;
        3'd5:    dlo2_q  <= mul_q;
        default: ;
      endcase
    end
    if (state_q == S_BIN) bin_q <= AW'(quotient);
    if ((state_q == S_RO_OUT) && slot_free) begin
      bin_number_q <= BIN_NUM_W'(p_eff);
      range_q      <= bad ? '0 : RANGE_W'(ro_val);
      last_q       <= ro_last;
      bad_q        <= bad;
    end
  end

  ptpms_cordic #(
    .COORD_BITS(COORD_BITS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cordic_start),
    .x_i    (px_q),
    .y_i    (py_q),
    .busy_o (cordic_busy),
    .done_o (cordic_done),
    .angle_o(angle)
  );

  ptpms_isqrt #(
    .IN_W(PLW)
  ) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cordic_start),
    .value_i(plane_q),
    .busy_o (sqrt_busy),
    .root_o (root)
  );

  ptpms_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(diff[DIVIDEND_W-1:0]),
    .divisor_i (step_q),
    .done_o    (div_done),
    .quotient_o(quotient)
  );

  ptpms_ram #(
    .WIDTH(STORE_W),
    .DEPTH(MAX_BINS),
    .AW   (AW)
  ) u_bins (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign bin_number_o = bin_number_q;
  assign range_mm_o   = range_q;
  assign last_bin_o   = last_q;
  assign config_bad_o = bad_q;

  // The angle unit only finishes while the sequencer waits for it.
  `PTPMS_ASSERT(a_cordic_done_state, cordic_done |-> (state_q == S_CORDIC) && !cordic_busy, "CORDIC finished outside its wait state")
  // The square root runs in the shadow of the angle unit.
  `PTPMS_ASSERT(a_sqrt_before_angle, cordic_done |-> !sqrt_busy, "square root still busy when the angle is ready")
  // A bad configuration reports a zero range.
  `PTPMS_ASSERT_NEVER(a_bad_zero_range, out_valid_o && config_bad_o && (range_mm_o != '0), "nonzero range with bad configuration")

endmodule

@@ test/tb_pointcloud_to_polar_min_scan_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polar minimum scan testbench
// Drives point and read-out requests with random gaps and output stalls, keeps
// its own model of the bin store and registers, and compares every scan result.
// ----------------------------------------------------------------------------
module tb_pointcloud_to_polar_min_scan_top;
  import ptpms_pkg::*;

  localparam int NUM_BINS   = 1024;
  localparam int CRD_W      = 24;
  localparam int CYCLE_MAX  = 3000000;
  localparam int DRAIN_WAIT = 120;
  localparam bit KIND_POINT = 1'b0;
  localparam bit KIND_READ  = 1'b1;

  typedef struct packed {
    logic [BIN_NUM_W-1:0] bin_number;
    logic [RANGE_W-1:0]   range_mm;
    logic                 last_bin;
    logic                 config_bad;
  } scan_result_t;

  typedef struct packed {
    logic                    kind;
    logic signed [CRD_W-1:0] x;
    logic signed [CRD_W-1:0] y;
    logic signed [CRD_W-1:0] z;
    logic                    typed;
    scan_result_t            res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic kind_i = 1'b0;
  logic signed [CRD_W-1:0] px_i = '0;
  logic signed [CRD_W-1:0] py_i = '0;
  logic signed [CRD_W-1:0] pz_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [BIN_NUM_W-1:0] bin_number_o;
  logic [RANGE_W-1:0] range_mm_o;
  logic last_bin_o;
  logic config_bad_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  pointcloud_to_polar_min_scan_top #(
    .MAX_BINS  (NUM_BINS),
    .COORD_BITS(CRD_W)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .px_i        (px_i),
    .py_i        (py_i),
    .pz_i        (pz_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .bin_number_o(bin_number_o),
    .range_mm_o  (range_mm_o),
    .last_bin_o  (last_bin_o),
    .config_bad_o(config_bad_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Local copy of the block state and registers.
  logic [STORE_W-1:0]       nearest_range [NUM_BINS];
  int unsigned              scan_ptr;
  logic signed [23:0]       z_top;
  logic signed [23:0]       z_floor;
  logic [22:0]              reach_max;
  logic [22:0]              reach_min;
  logic signed [START_W-1:0] sector_start;
  logic [STEP_W-1:0]        sector_width;
  logic [COUNT_W-1:0]       sector_count;
  longint                   arc_table [CORDIC_ITERS];

  scan_result_t pending_scan[$];
  int mismatches = 0;
  int results_seen = 0;
  int points_sent = 0;
  int reads_sent = 0;
  int cycles = 0;
  bit gaps_on = 1'b1;

  // Arctangent of 1/n in units of 2^-56 radian by its truncated series.
  function automatic longint unsigned arctan_inv(longint unsigned n);
    longint unsigned p, nn, acc, t, k;
    p = (64'd1 << 62) / n;
    nn = n * n;
    acc = 0;
    k = 0;
    while (p != 0) begin
      t = p / (2 * k + 1);
      if (k[0]) acc = acc - t;
      else acc = acc + t;
      p = p / nn;
      k++;
    end
    return acc >> 6;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned root, b;
    root = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v = v - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  // CORDIC vectoring angle, rounded to 2^-16 radian.
  function automatic longint heading(longint ax, longint ay);
    longint x, y, z, dx, dy, t;
    if (ax == 0 && ay == 0) return 0;
    x = ax * (64'sd1 <<< 37);
    y = ay * (64'sd1 <<< 37);
    z = 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 2 * arc_table[0];
      end else begin
        x = -y; y = t; z = -2 * arc_table[0];
      end
    end
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += arc_table[i];
      end else begin
        x -= dx; y += dy; z -= arc_table[i];
      end
    end
    return (z + (64'sd1 <<< 39)) >>> 40;
  endfunction

  function automatic int unsigned bins_active();
    if (sector_count == 0) return 1;
    return (sector_count > NUM_BINS) ? NUM_BINS : sector_count;
  endfunction

  // Applies one accepted request; returns 1 with the scan result for a read.
  function automatic bit scan_update(input stim_row_t r, output scan_result_t res);
    bit bad;
    longint x, y, z, diff;
    longint unsigned mx, my, mz, plane, d2, up, lo, bin, rng;
    int unsigned cnt, p;
    logic [STORE_W-1:0] val;
    res = '0;
    bad = (z_top < z_floor) || (reach_max < reach_min);
    if (r.kind == KIND_POINT) begin
      x = r.x; y = r.y; z = r.z;
      mx = (x < 0) ? -x : x;
      my = (y < 0) ? -y : y;
      mz = (z < 0) ? -z : z;
      plane = mx * mx + my * my;
      d2 = plane + mz * mz;
      up = reach_max;
      lo = reach_min;
      if (bad || sector_width == 0) return 0;
      if (z > longint'(z_top) || z <= longint'(z_floor)) return 0;
      if (d2 > up * up || d2 < lo * lo) return 0;
      diff = heading(x, y) - longint'(sector_start);
      if (diff < 0) return 0;
      bin = longint'(diff) / longint'(sector_width);
      if (bin >= bins_active()) return 0;
      rng = floor_sqrt(plane);
      if (rng > EMPTY_MARK) rng = EMPTY_MARK;
      if (rng < nearest_range[bin]) nearest_range[bin] = rng[STORE_W-1:0];
      return 0;
    end
    cnt = bins_active();
    p = scan_ptr;
    // A pointer left past a shrunken scan starts over at bin 0.
    if (p >= cnt) p = 0;
    val = nearest_range[p];
    if (val > STORE_W'(reach_max)) val = STORE_W'(reach_max);
    res.bin_number = p[BIN_NUM_W-1:0];
    res.range_mm = bad ? '0 : val[RANGE_W-1:0];
    res.last_bin = (p == cnt - 1);
    res.config_bad = bad;
    nearest_range[p] = EMPTY_MARK;
    scan_ptr = res.last_bin ? 0 : p + 1;
    return 1;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sends one request; called at a rising edge, returns at its acceptance.
  task automatic send_request(input stim_row_t r);
    int gap;
    scan_result_t res;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= r.kind;
    px_i <= r.x;
    py_i <= r.y;
    pz_i <= r.z;
    do @(posedge clk_i); while (!in_ready_o);
    if (r.kind == KIND_READ) reads_sent++;
    else points_sent++;
    if (scan_update(r, res))
      pending_scan.insert(pending_scan.size(), r.typed ? r.res : res);
  endtask

  // Waits for every pending result, then for a point still in flight.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_scan.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // Holds one register write until it is taken; the caller drops valid.
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_HEIGHT_UPPER: z_top = data[23:0];
      REG_HEIGHT_LOWER: z_floor = data[23:0];
      REG_DIST_UPPER:   reach_max = data[22:0];
      REG_DIST_LOWER:   reach_min = data[22:0];
      REG_ANGLE_START:  sector_start = data[START_W-1:0];
      REG_ANGLE_STEP:   sector_width = data[STEP_W-1:0];
      default:          sector_count = data[COUNT_W-1:0];
    endcase
  endtask

  task automatic set_scan(input int hu, input int hl, input int du, input int dl,
                          input int as, input int st, input int bc);
    write_reg(REG_HEIGHT_UPPER, hu[23:0]);
    write_reg(REG_HEIGHT_LOWER, hl[23:0]);
    write_reg(REG_DIST_UPPER, du[23:0]);
    write_reg(REG_DIST_LOWER, dl[23:0]);
    write_reg(REG_ANGLE_START, as[23:0]);
    write_reg(REG_ANGLE_STEP, st[23:0]);
    write_reg(REG_BIN_COUNT, bc[23:0]);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic signed [CRD_W-1:0] pick_coord(input int span);
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return CRD_W'($urandom_range(0, 2 * span) - span);
    if (r < 80) return CRD_W'($urandom_range(0, 40000) - 20000);
    if (r < 95) return CRD_W'($urandom);
    return '0;
  endfunction

  // Output side: random stalls and in-order comparison.
  int stall_mode = 0;
  always @(posedge clk_i) begin
    scan_result_t got, want;
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 3) != 0);
      default: out_ready_i <= ($urandom_range(0, 9) == 0);
    endcase
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{bin_number_o, range_mm_o, last_bin_o, config_bad_o};
      results_seen++;
      if (pending_scan.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected scan result: bin %0d range %0d last %0b bad %0b",
                   got.bin_number, got.range_mm, got.last_bin, got.config_bad);
      end else begin
        want = pending_scan.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
                     want.bin_number, want.range_mm, want.last_bin, want.config_bad,
                     got.bin_number, got.range_mm, got.last_bin, got.config_bad);
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_MAX) begin
      $display("Timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  stim_row_t directed [14];
  scan_result_t empty_res;

  initial begin
    stim_row_t r;
    int span;
    int bc;
    // Angle table and reset state of the local model.
    arc_table[0] = arctan_inv(2) + arctan_inv(3);
    for (int i = 1; i < CORDIC_ITERS; i++)
      arc_table[i] = (i < 20) ? arctan_inv(64'd1 << i) : (64'sd1 <<< (56 - i));
    foreach (nearest_range[i]) nearest_range[i] = EMPTY_MARK;
    scan_ptr = 0;
    z_top = 24'sd8388607;
    z_floor = -24'sd8388608;
    reach_max = 23'd8388607;
    reach_min = 23'd0;
    sector_start = -19'sd205888;
    sector_width = 19'd402;
    sector_count = 11'd1024;

    // Directed rows: empty reads after reset, coordinate extremes, origin,
    // both left-half turns, axis points and points landing in the first bins.
    empty_res = '{10'd0, 23'd8388607, 1'b0, 1'b0};
    directed[0]  = '{KIND_READ,  0, 0, 0, 1'b1, empty_res};
    directed[1]  = '{KIND_READ,  0, 0, 0, 1'b1, '{10'd1, 23'd8388607, 1'b0, 1'b0}};
    directed[2]  = '{KIND_POINT, 24'sd8388607, 24'sd8388607, 24'sd8388607, 1'b0, '0};
    directed[3]  = '{KIND_POINT, -24'sd8388608, -24'sd8388608, -24'sd8388608, 1'b0, '0};
    directed[4]  = '{KIND_POINT, -24'sd8388608, -24'sd1, 24'sd0, 1'b0, '0};
    directed[5]  = '{KIND_POINT, -24'sd5, 24'sd0, 24'sd0, 1'b0, '0};
    directed[6]  = '{KIND_POINT, -24'sd5000, -24'sd3, 24'sd10, 1'b0, '0};
    directed[7]  = '{KIND_POINT, 24'sd0, 24'sd0, 24'sd0, 1'b0, '0};
    directed[8]  = '{KIND_POINT, 24'sd0, -24'sd700, -24'sd8388608, 1'b0, '0};
    directed[9]  = '{KIND_POINT, 24'sd1200, 24'sd0, 24'sd8388607, 1'b0, '0};
    directed[10] = '{KIND_POINT, -24'sd9000, -24'sd2, 24'sd0, 1'b0, '0};
    directed[11] = '{KIND_READ,  0, 0, 0, 1'b0, '0};
    directed[12] = '{KIND_READ,  0, 0, 0, 1'b0, '0};
    directed[13] = '{KIND_READ,  0, 0, 0, 1'b0, '0};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_request(directed[i]);
    drain();

    // Phases of settings, each followed by random requests.
    for (int ph = 0; ph < 12; ph++) begin
      gaps_on = (ph % 4 != 3);
      span = 3000;
      case (ph)
        0:  set_scan(2000, -2000, 20000, 50, -205888, 51473, 8);
        1:  set_scan(8388607, -8388608, 8388607, 0, -205888, 411775, 1);
        2:  set_scan(8388607, -8388608, 8388607, 0, $urandom_range(0, 4000) - 2000, 1, 1024);
        3:  set_scan(3000, -3000, 30000, 0, -205888, 100000, 0);
        4:  set_scan(5000, -5000, 8388607, 0, -205888, 402, 2047);
        5:  set_scan(-10, 10, 20000, 0, -205888, 51473, 8);
        6:  set_scan(2000, -2000, 10, 100, -205888, 51473, 8);
        7:  set_scan(2000, -2000, 20000, 0, -205888, 0, 8);
        8:  set_scan(2000, -2000, 20000, 0, -205888, 12868, 32);
        9:  set_scan(2000, -2000, 20000, 0, 205888, 137259, 3);
        default: begin
          bc = $urandom_range(1, 64);
          span = $urandom_range(100, 20000);
          set_scan($urandom_range(0, 3000), -$urandom_range(0, 3000),
                   $urandom_range(1000, 8388607), $urandom_range(0, 200),
                   $urandom_range(0, 411776) - 205888,
                   411776 / bc + $urandom_range(0, 2000), bc);
        end
      endcase
      @(posedge clk_i);
      for (int n = 0; n < 150; n++) begin
        r = '0;
        r.kind = ($urandom_range(0, 99) < 35) ? KIND_READ : KIND_POINT;
        r.x = pick_coord(span);
        r.y = pick_coord(span);
        r.z = ($urandom_range(0, 9) < 7) ? CRD_W'($urandom_range(0, 4000) - 2000)
                                         : CRD_W'($urandom);
        send_request(r);
      end
      // Pending results of this phase are drained before the settings change.
      drain();
    end
    drain();

    $display("Covered %0d point and %0d read-out requests (%0d results) over 13 settings,",
             points_sent, reads_sent, results_seen);
    $display("including bad limits, zero step, bin count extremes and pointer wrap.");
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("Mismatch count %0d", mismatches);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
